// ===== rtl/core/tte_pkg.sv =====
// Shared constants and controller/datapath interface types for the tap tempo estimator.
package tte_pkg;

    // Divider geometry
    localparam int DIV_W  = 32;
    localparam int STEP_W = 6;

    // Milliseconds in one minute and the bits it occupies
    localparam int MINUTE_MS = 60000;
    localparam int MINUTE_W  = 16;

    localparam logic [15:0] TEMPO_SAT       = 16'hFFFF;
    localparam logic [7:0]  MIN_TEMPO_RESET = 8'd30;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;     // latch tap time, read newest entry
        logic gap_div;    // start 60000 / gap
        logic append;     // push tap into window, read oldest entry
        logic span_div;   // start num / span
        logic span_sat;   // zero span: saturated tempo
        logic take_quot;  // tempo from divider quotient
        logic restart;    // window restarts with this tap alone
        logic finish;     // load the output register
    } tte_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic window_empty;
        logic gap_zero;
        logic div_done;
        logic tap_fast;
        logic span_zero;
        logic out_free;
    } tte_stat_t;

endpackage

// ===== rtl/core/tte_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [WIDTH-1:0]           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/tte_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, pre-aligned dividend.
module tte_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tte_pkg::DIV_W-1:0]     dividend,
    input  logic [tte_pkg::DIV_W-1:0]     divisor,
    input  logic [tte_pkg::STEP_W-1:0]    steps,
    output logic                          done,
    output logic [tte_pkg::DIV_W-1:0]     quotient
);
    import tte_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   cnt_reg;
    logic [DIV_W-1:0]    quo_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [DIV_W-1:0]    dvs_reg;

    logic [DIV_W:0]      part;
    logic [DIV_W:0]      part_sub;
    logic                fits;

    // Trial subtraction for the next quotient bit
    always_comb
    begin
        part     = {rem_reg, quo_reg[DIV_W-1]};
        part_sub = part - {1'b0, dvs_reg};
        fits     = (part >= {1'b0, dvs_reg});
    end

    // Step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == STEP_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? part_sub[DIV_W-1:0] : part[DIV_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/tte_dp.sv =====
// Datapath: tap window in RAM, window pointers, shared divider, result and output registers.
module tte_dp #(
    parameter int MAX_TAPS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [31:0]          tap_time_ms,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           min_tempo_bpm,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 tempo_updated,
    output logic [15:0]          tempo_bpm,
    output logic [3:0]           taps_held,
    input  tte_pkg::tte_cmd_t    cmd,
    output tte_pkg::tte_stat_t   stat
);
    import tte_pkg::*;

    localparam int PTR_W = $clog2(MAX_TAPS);
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int NUM_W = $clog2(MINUTE_MS * (MAX_TAPS - 1) + 1);

    // Circular window: head is the oldest entry, tail the newest
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [7:0]        min_tempo_reg;
    logic [31:0]       now_reg;
    logic [NUM_W-1:0]  num_reg;
    logic              res_updated_reg;
    logic [15:0]       res_tempo_reg;
    logic              out_valid_reg, out_valid_next;
    logic              out_updated_reg;
    logic [15:0]       out_tempo_reg;
    logic [3:0]        out_taps_reg;

    logic              full;
    logic [PTR_W-1:0]  head_after;
    logic [CNT_W-1:0]  num_mult;
    logic [CNT_W+3:0]  cnt_ext;

    logic              ram_wr_en;
    logic [PTR_W-1:0]  ram_wr_addr;
    logic              ram_rd_en;
    logic [PTR_W-1:0]  ram_rd_addr;
    logic [31:0]       ram_rd_data;
    logic [31:0]       diff;

    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [STEP_W-1:0] div_steps;
    logic              div_done;
    logic [DIV_W-1:0]  div_q;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(MAX_TAPS - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    // Window bookkeeping
    always_comb
    begin
        full       = (count_reg == CNT_W'(MAX_TAPS));
        head_after = full ? ptr_inc(head_reg) : head_reg;
        num_mult   = full ? CNT_W'(MAX_TAPS - 1) : count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.restart)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = CNT_W'(1);
        end
        else if (cmd.append)
        begin
            head_next  = head_after;
            tail_next  = ptr_inc(tail_reg);
            count_next = full ? count_reg : count_reg + CNT_W'(1);
        end
    end

    // Tap time storage
    assign ram_wr_en   = cmd.append | cmd.restart;
    assign ram_wr_addr = cmd.append ? ptr_inc(tail_reg) : '0;
    assign ram_rd_en   = cmd.accept | cmd.append;
    assign ram_rd_addr = cmd.append ? head_after : tail_reg;

    tte_ram #(
        .WIDTH (32),
        .DEPTH (MAX_TAPS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (now_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Gap or span, wrapping modulo 2^32
    assign diff = now_reg - ram_rd_data;

    // Shared divider: 60000 / gap, then 60000*(taps-1) / span
    assign div_start    = cmd.gap_div | cmd.span_div;
    assign div_dividend = cmd.gap_div
                        ? {16'(MINUTE_MS), {(DIV_W - MINUTE_W){1'b0}}}
                        : {num_reg, {(DIV_W - NUM_W){1'b0}}};
    assign div_steps    = cmd.gap_div ? STEP_W'(MINUTE_W) : STEP_W'(NUM_W);

    tte_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (diff),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (div_q)
    );

    // Status to the controller
    always_comb
    begin
        stat.window_empty = (count_reg == '0);
        stat.gap_zero     = (diff == '0);
        stat.span_zero    = (diff == '0);
        stat.div_done     = div_done;
        stat.tap_fast     = (div_q > {{(DIV_W - 8){1'b0}}, min_tempo_reg});
        stat.out_free     = !out_valid_reg || !result_stall;
    end

    // Output handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            min_tempo_reg <= MIN_TEMPO_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                min_tempo_reg <= min_tempo_bpm;
            end
        end
    end

    assign cnt_ext = {4'b0000, count_reg};

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            now_reg <= tap_time_ms;
        end
        if (cmd.append)
        begin
            num_reg <= NUM_W'(MINUTE_MS * int'(num_mult));
        end
        if (cmd.restart)
        begin
            res_updated_reg <= 1'b0;
            res_tempo_reg   <= '0;
        end
        else if (cmd.span_sat)
        begin
            res_updated_reg <= 1'b1;
            res_tempo_reg   <= TEMPO_SAT;
        end
        else if (cmd.take_quot)
        begin
            res_updated_reg <= 1'b1;
            res_tempo_reg   <= (div_q[DIV_W-1:16] != '0) ? TEMPO_SAT : div_q[15:0];
        end
        if (cmd.finish)
        begin
            out_updated_reg <= res_updated_reg;
            out_tempo_reg   <= res_tempo_reg;
            out_taps_reg    <= cnt_ext[3:0];
        end
    end

    assign cfg_ready     = 1'b1;
    assign result_valid  = out_valid_reg;
    assign tempo_updated = out_updated_reg;
    assign tempo_bpm     = out_tempo_reg;
    assign taps_held     = out_taps_reg;

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TAPS))
        else $error("tap count beyond window size");

    a_append_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> count_reg != '0)
        else $error("append to an empty window");

    a_append_two: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |=> count_reg >= CNT_W'(2))
        else $error("window below two taps after append");

    a_finish_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || !result_stall))
        else $error("result overwrites a pending transaction");

endmodule

// ===== rtl/core/tte_ctrl.sv =====
// Controller: sequences one tap through gap check, window update and tempo division.
module tte_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tap_valid,
    output logic                 tap_stall,
    input  tte_pkg::tte_stat_t   stat,
    output tte_pkg::tte_cmd_t    cmd
);
    import tte_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_GAP     = 3'd1;
    localparam logic [2:0] S_DIV1    = 3'd2;
    localparam logic [2:0] S_APPEND  = 3'd3;
    localparam logic [2:0] S_RDOLD   = 3'd4;
    localparam logic [2:0] S_DIV2    = 3'd5;
    localparam logic [2:0] S_RESTART = 3'd6;
    localparam logic [2:0] S_OUT     = 3'd7;

    logic [2:0] state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        tap_stall  = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                tap_stall = 1'b0;
                if (tap_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.window_empty ? S_RESTART : S_GAP;
                end
            end
            S_GAP:
            begin
                if (stat.gap_zero)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    cmd.gap_div = 1'b1;
                    state_next  = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (stat.div_done)
                begin
                    state_next = stat.tap_fast ? S_APPEND : S_RESTART;
                end
            end
            S_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = S_RDOLD;
            end
            S_RDOLD:
            begin
                if (stat.span_zero)
                begin
                    cmd.span_sat = 1'b1;
                    state_next   = S_OUT;
                end
                else
                begin
                    cmd.span_div = 1'b1;
                    state_next   = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (stat.div_done)
                begin
                    cmd.take_quot = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_RESTART:
            begin
                cmd.restart = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/tap_tempo_estimator_unit.sv =====
// Tap tempo estimator: top level joining the controller and the datapath.
//
// Usage: each transaction on the tap channel (tap_valid/tap_stall) carries one
// millisecond timestamp and produces exactly one transaction on the result
// channel (result_valid/result_stall) with tempo_updated, tempo_bpm, taps_held.
// min_tempo_bpm is written through cfg_valid/cfg_ready; cfg_ready is always
// high, and the register is meant to change only while no tap is in flight.
// One tap is processed at a time; the shared bit-serial divider sets the rate.
// Path of a tap: the first tap after an empty window restarts it at once,
// a slow tap passes the 16-step gap division and then restarts it, a tap
// joining the window passes the gap division, the append and the span
// division of N = clog2(60000 * (MAX_TAPS - 1) + 1) steps (19 at 8 taps),
// and a zero gap skips the gap division. A zero span skips the span division.
// The next tap is taken the cycle after its predecessor's result is loaded.
// The result sits in an output register, so a stalled receiver holds it while
// the next tap is already accepted; a second result then waits until the
// first transaction completes. Reset empties the window, clears result_valid
// and sets min_tempo_bpm to 30.
module tap_tempo_estimator_unit #(
    parameter int MAX_TAPS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         tap_valid,
    output logic         tap_stall,
    input  logic [31:0]  tap_time_ms,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   min_tempo_bpm,
    output logic         result_valid,
    input  logic         result_stall,
    output logic         tempo_updated,
    output logic [15:0]  tempo_bpm,
    output logic [3:0]   taps_held
);
    import tte_pkg::*;

    tte_cmd_t  cmd;
    tte_stat_t stat;

    // Sequencer
    tte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .tap_valid (tap_valid),
        .tap_stall (tap_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Window storage, divider and output register
    tte_dp #(
        .MAX_TAPS (MAX_TAPS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .tap_time_ms   (tap_time_ms),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .min_tempo_bpm (min_tempo_bpm),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .tempo_updated (tempo_updated),
        .tempo_bpm     (tempo_bpm),
        .taps_held     (taps_held),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule
